// ===== src/wide_unsigned_integer_alu_top_assert.svh =====
// Assertion macros used by the wide unsigned ALU controller.
`ifndef WIDE_UNSIGNED_INTEGER_ALU_TOP_ASSERT_SVH
`define WIDE_UNSIGNED_INTEGER_ALU_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define WUA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WUA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WUA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define WUA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/wua_pkg.sv =====
// Types and constants shared by the wide unsigned ALU.
`default_nettype none

package wua_pkg;

    localparam int LOW_W   = 64;
    localparam int HIGH_W  = 32;
    localparam int FIELD_W = LOW_W + HIGH_W;
    localparam int EXT_W   = 128;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CARRY   = 2'd1,
        ST_BORROW  = 2'd2,
        ST_DIVZERO = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic iter_op;
        logic zero_divisor;
    } flags_t;

endpackage

`default_nettype wire

// ===== src/wide_unsigned_integer_alu_top.sv =====
// Top level of the wide unsigned ALU: controller plus datapath.
//
// Input channel: in_valid / in_stall with opcode and the two operands, each given
// as a 64-bit low part and a 32-bit high part. An item is taken at a clock edge
// where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with result, remainder and status; the
// result is taken at an edge where out_valid is high and out_stall is low.
// Add and subtract use the wide adder and subtractor at load; the result is held in
// S_DONE and then published to the output register, as is a divide by a zero divisor.
// Multiply and divide run MANT_BITS steps of one shared adder (shift-and-add, restoring
// shift-and-subtract) in S_RUN, then pass through S_DONE to the output register.
// One item is worked on at a time; the next item is taken the cycle after the
// previous result lands in the output register. A finished result waits there
// while out_stall is high; a new item may still be taken meanwhile, and its result
// waits until that one leaves. Reset clears the controller and drops out_valid.
`default_nettype none

module wide_unsigned_integer_alu_top
    import wua_pkg::*;
#(
    parameter int MANT_BITS = 96
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          opcode,
    input  wire logic [LOW_W-1:0]    a_low,
    input  wire logic [HIGH_W-1:0]   a_high,
    input  wire logic [LOW_W-1:0]    b_low,
    input  wire logic [HIGH_W-1:0]   b_high,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [LOW_W-1:0]         result_low,
    output logic [HIGH_W-1:0]        result_high,
    output logic [LOW_W-1:0]         rem_low,
    output logic [HIGH_W-1:0]        rem_high,
    output logic [1:0]               status
);

    cmd_t   cmd;
    flags_t flags;

    wua_ctrl #(
        .MANT_BITS (MANT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .flags     (flags),
        .cmd       (cmd)
    );

    wua_datapath #(
        .MANT_BITS (MANT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .flags       (flags),
        .opcode      (opcode),
        .a_low       (a_low),
        .a_high      (a_high),
        .b_low       (b_low),
        .b_high      (b_high),
        .result_low  (result_low),
        .result_high (result_high),
        .rem_low     (rem_low),
        .rem_high    (rem_high),
        .status      (status)
    );

endmodule

`default_nettype wire

// ===== src/wua_datapath.sv =====
// Datapath: operand registers, shared adder for the iterative steps, result registers.
`default_nettype none

module wua_datapath
    import wua_pkg::*;
#(
    parameter int MANT_BITS = 96
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output flags_t                   flags,
    input  wire logic [1:0]          opcode,
    input  wire logic [LOW_W-1:0]    a_low,
    input  wire logic [HIGH_W-1:0]   a_high,
    input  wire logic [LOW_W-1:0]    b_low,
    input  wire logic [HIGH_W-1:0]   b_high,
    output logic [LOW_W-1:0]         result_low,
    output logic [HIGH_W-1:0]        result_high,
    output logic [LOW_W-1:0]         rem_low,
    output logic [HIGH_W-1:0]        rem_high,
    output logic [1:0]               status
);

    localparam int W = MANT_BITS;

    op_t             op_in;
    logic [EXT_W-1:0] a_ext;
    logic [EXT_W-1:0] b_ext;
    logic [W-1:0]    a_w;
    logic [W-1:0]    b_w;
    logic [W:0]      sum_in;
    logic [W:0]      diff_in;

    op_t             op_reg;
    logic [W-1:0]    acc_reg;
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    opnd_reg;
    logic [W-1:0]    sh_reg;
    logic            flag_reg;
    logic            dz_reg;

    logic            is_mul;
    logic [W-1:0]    acc_shl;
    logic [W-1:0]    rem_shl;
    logic [W:0]      add_x;
    logic [W:0]      add_y;
    logic [W:0]      add_s;
    logic            take;

    logic [W-1:0]    res_fin;
    logic [EXT_W-1:0] res_ext;
    logic [EXT_W-1:0] rem_ext;
    status_t         status_fin;

    logic [LOW_W-1:0]  result_low_reg;
    logic [HIGH_W-1:0] result_high_reg;
    logic [LOW_W-1:0]  rem_low_reg;
    logic [HIGH_W-1:0] rem_high_reg;
    status_t           status_reg;

    assign op_in = op_t'(opcode);
    assign a_ext = EXT_W'({a_high, a_low});
    assign b_ext = EXT_W'({b_high, b_low});
    assign a_w   = a_ext[W-1:0];
    assign b_w   = b_ext[W-1:0];

    assign sum_in  = {1'b0, a_w} + {1'b0, b_w};
    assign diff_in = {1'b0, a_w} - {1'b0, b_w};

    assign flags.iter_op      = (op_in == OP_MUL) || (op_in == OP_DIV);
    assign flags.zero_divisor = (op_in == OP_DIV) && (b_w == '0);

    // One adder serves both loops: add for multiply, subtract for divide.
    assign is_mul  = (op_reg == OP_MUL);
    assign acc_shl = {acc_reg[W-2:0], 1'b0};
    assign rem_shl = {rem_reg[W-2:0], sh_reg[W-1]};
    assign add_x   = is_mul ? {1'b0, acc_shl} : {1'b0, rem_shl};
    assign add_y   = is_mul ? {1'b0, (sh_reg[W-1] ? opnd_reg : {W{1'b0}})}
                            : ~{1'b0, opnd_reg};
    assign add_s   = add_x + add_y + {{W{1'b0}}, ~is_mul};
    // bit W of the subtraction is the borrow; a set top bit always fits
    assign take    = rem_reg[W-1] | ~add_s[W];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_in;
            rem_reg  <= '0;
            opnd_reg <= (op_in == OP_MUL) ? a_w : b_w;
            sh_reg   <= (op_in == OP_MUL) ? b_w : a_w;
            dz_reg   <= flags.zero_divisor;
            case (op_in)
                OP_ADD:
                begin
                    acc_reg  <= sum_in[W-1:0];
                    flag_reg <= sum_in[W];
                end
                OP_SUB:
                begin
                    acc_reg  <= diff_in[W-1:0];
                    flag_reg <= diff_in[W];
                end
                default:
                begin
                    acc_reg  <= '0;
                    flag_reg <= 1'b0;
                end
            endcase
        end
        else if (cmd.step)
        begin
            sh_reg <= {sh_reg[W-2:0], 1'b0};
            if (is_mul)
            begin
                acc_reg  <= add_s[W-1:0];
                flag_reg <= flag_reg | acc_reg[W-1] | add_s[W];
            end
            else
            begin
                acc_reg <= {acc_reg[W-2:0], take};
                rem_reg <= take ? add_s[W-1:0] : rem_shl;
            end
        end
    end

    always_comb
    begin
        res_fin    = acc_reg;
        status_fin = ST_OK;
        case (op_reg)
            OP_ADD: status_fin = flag_reg ? ST_CARRY : ST_OK;
            OP_SUB: status_fin = flag_reg ? ST_BORROW : ST_OK;
            OP_MUL:
            begin
                status_fin = flag_reg ? ST_CARRY : ST_OK;
                if (flag_reg)
                begin
                    res_fin = '0;
                end
            end
            OP_DIV: status_fin = dz_reg ? ST_DIVZERO : ST_OK;
            default: status_fin = ST_OK;
        endcase
    end

    assign res_ext = EXT_W'(res_fin);
    assign rem_ext = EXT_W'(rem_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_low_reg  <= '0;
            result_high_reg <= '0;
            rem_low_reg     <= '0;
            rem_high_reg    <= '0;
            status_reg      <= ST_OK;
        end
        else if (cmd.publish)
        begin
            result_low_reg  <= res_ext[LOW_W-1:0];
            result_high_reg <= res_ext[FIELD_W-1:LOW_W];
            rem_low_reg     <= rem_ext[LOW_W-1:0];
            rem_high_reg    <= rem_ext[FIELD_W-1:LOW_W];
            status_reg      <= status_fin;
        end
    end

    assign result_low  = result_low_reg;
    assign result_high = result_high_reg;
    assign rem_low     = rem_low_reg;
    assign rem_high    = rem_high_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

// ===== src/wua_ctrl.sv =====
// Controller: item handshake, step counter and output valid.
`default_nettype none

`include "wide_unsigned_integer_alu_top_assert.svh"

module wua_ctrl
    import wua_pkg::*;
#(
    parameter int MANT_BITS = 96
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  wire logic   out_stall,
    input  wire flags_t flags,
    output cmd_t        cmd
);

    localparam int CNT_W = $clog2(MANT_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             out_free;
    logic             run_needed;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    // multiply and divide iterate; a zero divisor skips the loop
    assign run_needed = flags.iter_op && !flags.zero_divisor;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(MANT_BITS - 1);
                    state_next = run_needed ? S_RUN : S_DONE;
                end
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `WUA_ASSERT_NEXT(a_last_step_done, clk, rst_n, (state_reg == S_RUN) && (cnt_reg == '0), state_reg == S_DONE)
    `WUA_ASSERT_NEXT(a_short_op_done, clk, rst_n, accept && !run_needed, state_reg == S_DONE)
    `WUA_ASSERT_NEXT(a_held_result_kept, clk, rst_n, out_valid_reg && out_stall, out_valid_reg)
    `WUA_ASSERT_SAME(a_publish_when_free, clk, rst_n, cmd.publish, out_free && (state_reg == S_DONE))

endmodule

`default_nettype wire
